// ----- src/dotq_pkg.sv -----
// Shared types, field widths and command codes for the deadline-ordered timer queue.
// Used by dotq_cell, dotq_deadline_calc and deadline_ordered_timer_queue_core.
package dotq_pkg;

  localparam int DEFAULT_CAPACITY   = 32;
  localparam int DEFAULT_TIME_WIDTH = 32;

  localparam int MODE_W   = 2;
  localparam int DELAY_W  = 24;
  localparam int TAG_W    = 16;
  localparam int ACTION_W = 8;
  localparam int TPU_W    = 16;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 6;
  localparam int PROD_W   = DELAY_W + TPU_W;

  localparam int S_TDATA_W = 48;  // delay, tag, action
  localparam int M_TDATA_W = 32;  // out_tag, out_action, accepted, count, pad

  // Input modes
  localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  // Chain commands
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_POP    = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [TAG_W-1:0]    tag;
    logic [ACTION_W-1:0] action;
  } entry_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [TAG_W-1:0]    tag;
    logic [ACTION_W-1:0] action;
  } cell_ctrl_t;

  localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, tag: '0, action: '0};

endpackage

// ----- src/dotq_cell.sv -----
// One slot of the sorted timer chain: a valid bit, deadline, tag and action.
// Depends on dotq_pkg for entry_t, cell_ctrl_t and the chain command codes.
module dotq_cell #(
  parameter int TIME_WIDTH = dotq_pkg::DEFAULT_TIME_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dotq_pkg::cell_ctrl_t   ctrl,
  input  logic [TIME_WIDTH-1:0]  new_deadline,
  input  dotq_pkg::entry_t       left_entry,
  input  logic [TIME_WIDTH-1:0]  left_deadline,
  input  dotq_pkg::entry_t       right_entry,
  input  logic [TIME_WIDTH-1:0]  right_deadline,
  input  logic                   keep_in,
  input  logic                   hit_in,
  output logic                   keep_out,
  output logic                   hit_out,
  output dotq_pkg::entry_t       entry,
  output logic [TIME_WIDTH-1:0]  deadline
);
  import dotq_pkg::*;

  logic                  valid;
  logic [TAG_W-1:0]      tag;
  logic [ACTION_W-1:0]   action;
  entry_t                ent;
  entry_t                ent_next;
  logic [TIME_WIDTH-1:0] dl;
  logic [TIME_WIDTH-1:0] dl_next;
  logic [TIME_WIDTH-1:0] diff;

  assign ent = '{valid: valid, tag: tag, action: action};

  // Own deadline at or before the new one (wrap-safe): stay ahead of it.
  assign diff     = new_deadline - dl;
  assign keep_out = keep_in && ent.valid && !diff[TIME_WIDTH-1];
  assign hit_out  = hit_in || (ent.valid && (ent.tag == ctrl.tag));

  always_comb begin
    ent_next = ent;
    dl_next  = dl;
    case (ctrl.cmd)
      CMD_INSERT: begin
        if (!keep_out) begin
          if (keep_in) begin
            ent_next = '{valid: 1'b1, tag: ctrl.tag, action: ctrl.action};
            dl_next  = new_deadline;
          end else begin
            ent_next = left_entry;
            dl_next  = left_deadline;
          end
        end
      end
      CMD_REMOVE: begin
        if (hit_out) begin
          ent_next = right_entry;
          dl_next  = right_deadline;
        end
      end
      CMD_POP: begin
        ent_next = right_entry;
        dl_next  = right_deadline;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ent_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag    <= ent_next.tag;
    action <= ent_next.action;
    dl     <= dl_next;
  end

  assign entry    = ent;
  assign deadline = dl;

endmodule

// ----- src/dotq_deadline_calc.sv -----
// Deadline unit: registered delay * ticks_per_unit, then saturate and add to now.
// Depends on dotq_pkg for field widths; two register stages, free running.
module dotq_deadline_calc #(
  parameter int TIME_WIDTH = dotq_pkg::DEFAULT_TIME_WIDTH
) (
  input  logic                          clk,
  input  logic [dotq_pkg::DELAY_W-1:0]  delay,
  input  logic [dotq_pkg::TPU_W-1:0]    ticks_per_unit,
  input  logic [TIME_WIDTH-1:0]         now,
  output logic [TIME_WIDTH-1:0]         deadline
);
  import dotq_pkg::*;

  localparam int CAP_BITS = (TIME_WIDTH - 1 < 31) ? TIME_WIDTH - 1 : 31;
  localparam logic [PROD_W-1:0] DIST_CAP = (PROD_W'(1) << CAP_BITS) - PROD_W'(1);
  localparam int SUM_W = (TIME_WIDTH > PROD_W) ? TIME_WIDTH : PROD_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] dist_sat;
  logic [SUM_W-1:0]  dist_ext;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(delay) * PROD_W'(ticks_per_unit);
  end

  // Clamp the distance so it stays inside the wrap-safe half range.
  assign dist_sat = (prod > DIST_CAP) ? DIST_CAP : prod;
  assign dist_ext = SUM_W'(dist_sat);

  always_ff @(posedge clk) begin
    deadline <= now + dist_ext[TIME_WIDTH-1:0];
  end

endmodule

// ----- src/deadline_ordered_timer_queue_core.sv -----
// Deadline-ordered timer queue: top level with control sequencer and output register.
// Depends on dotq_pkg, dotq_cell and dotq_deadline_calc.
//
// Holds up to CAPACITY timers in a chain of cells sorted by deadline, head in
// cell 0, equal deadlines first in, first out. Each input item (tuser = mode)
// is worked on alone; s_tready is high only while the sequencer is idle.
// A register item is latched at acceptance, the delay * ticks_per_unit product
// is registered, then saturated and added to the current time, and last every
// cell compares its deadline against the new one and the chain opens a gap and
// inserts in place, as its status result is emitted. A cancel item removes one
// matching timer per cycle (the chain closes the gap behind the first match),
// then emits a summary. A tick item advances the time counter at acceptance,
// then pops one expired head per cycle while the output register is free,
// emitting it, and ends with a summary. Each result waits for the single output
// register to free up, so a stalled master side holds the sequencer. Mode 3 is
// dropped with no result. ticks_per_unit is written through cfg_wr_en/cfg_wr_data
// and must only change while the block is idle. No clearing pass: reset clears
// the cell valid bits, time counter, count, state and m_tvalid; ticks_per_unit goes to 1.
module deadline_ordered_timer_queue_core #(
  parameter int CAPACITY   = dotq_pkg::DEFAULT_CAPACITY,
  parameter int TIME_WIDTH = dotq_pkg::DEFAULT_TIME_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: ticks_per_unit
  input  logic                            cfg_wr_en,
  input  logic [dotq_pkg::TPU_W-1:0]      cfg_wr_data,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dotq_pkg::S_TDATA_W-1:0]  s_tdata,  // [23:0] delay, [39:24] tag, [47:40] action
  input  logic [dotq_pkg::MODE_W-1:0]     s_tuser,  // [1:0] mode
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dotq_pkg::M_TDATA_W-1:0]  m_tdata,  // [15:0] out_tag, [23:16] out_action,
                                                    // [24] accepted, [30:25] count, [31] zero
  output logic [dotq_pkg::KIND_W-1:0]     m_tuser,  // [1:0] kind
  output logic                            m_tlast
);
  import dotq_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_CAN  = 3'd4;
  localparam logic [2:0] ST_TICK = 3'd5;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [TPU_W-1:0]      ticks_per_unit;
  logic [TIME_WIDTH-1:0] now;
  logic [COUNT_W-1:0]    cnt;

  // Latched input fields
  logic [DELAY_W-1:0]    delay_q;
  logic [TAG_W-1:0]      tag_q;
  logic [ACTION_W-1:0]   action_q;

  logic [TIME_WIDTH-1:0] new_deadline;
  logic                  s_accept;
  logic                  slot_free;
  logic                  emit;
  logic [KIND_W-1:0]     emit_kind;
  logic [TAG_W-1:0]      emit_tag;
  logic [ACTION_W-1:0]   emit_action;
  logic                  emit_accepted;
  logic                  emit_last;
  logic                  cnt_inc;
  cell_ctrl_t            ctrl;

  // Chain wiring
  entry_t                ents [CAPACITY];
  logic [TIME_WIDTH-1:0] dls  [CAPACITY];
  logic [CAPACITY:0]     keep_chain;
  logic [CAPACITY:0]     hit_chain;
  logic                  full;
  logic                  any_hit;
  logic                  head_fires;
  logic [TIME_WIDTH-1:0] head_age;

  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TPU_W'(1);
    end else if (cfg_wr_en) begin
      ticks_per_unit <= cfg_wr_data;
    end
  end

  // Latch the item fields at acceptance
  always_ff @(posedge clk) begin
    if (s_accept) begin
      delay_q  <= s_tdata[DELAY_W-1:0];
      tag_q    <= s_tdata[DELAY_W+TAG_W-1:DELAY_W];
      action_q <= s_tdata[DELAY_W+TAG_W+ACTION_W-1:DELAY_W+TAG_W];
    end
  end

  dotq_deadline_calc #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_calc (
    .clk            (clk),
    .delay          (delay_q),
    .ticks_per_unit (ticks_per_unit),
    .now            (now),
    .deadline       (new_deadline)
  );

  // Cell chain: keep runs head to tail for insert, hit marks the first cancel match
  assign keep_chain[0] = 1'b1;
  assign hit_chain[0]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t                left_e;
    entry_t                right_e;
    logic [TIME_WIDTH-1:0] left_d;
    logic [TIME_WIDTH-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_e = ENTRY_EMPTY;
      assign left_d = '0;
    end else begin : g_mid
      assign left_e = ents[i-1];
      assign left_d = dls[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = ENTRY_EMPTY;
      assign right_d = '0;
    end else begin : g_body
      assign right_e = ents[i+1];
      assign right_d = dls[i+1];
    end

    dotq_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .new_deadline   (new_deadline),
      .left_entry     (left_e),
      .left_deadline  (left_d),
      .right_entry    (right_e),
      .right_deadline (right_d),
      .keep_in        (keep_chain[i]),
      .hit_in         (hit_chain[i]),
      .keep_out       (keep_chain[i+1]),
      .hit_out        (hit_chain[i+1]),
      .entry          (ents[i]),
      .deadline       (dls[i])
    );
  end

  assign full       = ents[CAPACITY-1].valid;
  assign any_hit    = hit_chain[CAPACITY];
  // Head has expired when now - deadline lies in the lower half range
  assign head_age   = now - dls[0];
  assign head_fires = ents[0].valid && !head_age[TIME_WIDTH-1];

  // Sequencer: pick the chain command and the result to emit
  always_comb begin
    state_next    = state;
    ctrl          = '{cmd: CMD_HOLD, tag: tag_q, action: action_q};
    emit          = 1'b0;
    emit_kind     = KIND_STATUS;
    emit_tag      = '0;
    emit_action   = '0;
    emit_accepted = 1'b0;
    emit_last     = 1'b0;
    cnt_inc       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          case (s_tuser)
            MODE_REGISTER: state_next = ST_MUL;
            MODE_CANCEL:   state_next = ST_CAN;
            MODE_TICK:     state_next = ST_TICK;
            default:       state_next = ST_IDLE;  // drop unknown mode
          endcase
        end
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_INS;
      ST_INS: begin
        if (slot_free) begin
          emit          = 1'b1;
          emit_kind     = KIND_STATUS;
          emit_accepted = !full;
          emit_last     = 1'b1;
          if (!full) begin
            ctrl.cmd = CMD_INSERT;
          end
          state_next = ST_IDLE;
        end
      end
      ST_CAN: begin
        if (any_hit) begin
          ctrl.cmd = CMD_REMOVE;
          cnt_inc  = 1'b1;
        end else if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_SUMMARY;
          emit_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (slot_free) begin
          emit = 1'b1;
          if (head_fires) begin
            ctrl.cmd    = CMD_POP;
            cnt_inc     = 1'b1;
            emit_kind   = KIND_FIRED;
            emit_tag    = ents[0].tag;
            emit_action = ents[0].action;
          end else begin
            emit_kind  = KIND_SUMMARY;
            emit_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      now   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      // Advance time as a tick item enters; restart the count on every item
      if (s_accept) begin
        cnt <= '0;
        if (s_tuser == MODE_TICK) begin
          now <= now + TIME_WIDTH'(1);
        end
      end else if (cnt_inc) begin
        cnt <= cnt + COUNT_W'(1);
      end
    end
  end

  // Output register: hold until taken, load a new result when the slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= emit_kind;
      m_tlast <= emit_last;
      m_tdata <= {1'b0,
                  (emit_kind == KIND_SUMMARY) ? cnt : COUNT_W'(0),
                  emit_accepted,
                  emit_action,
                  emit_tag};
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for deadline_ordered_timer_queue_core: registers, cancels and ticks timers
// through the stream ports and compares every result item with a behavioral queue predictor.
// Depends on dotq_pkg and the core RTL in src/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dotq_pkg::*;

  localparam int QUEUE_DEPTH = DEFAULT_CAPACITY;
  localparam int TW = DEFAULT_TIME_WIDTH;
  localparam int RUN_LIMIT = 2000000;
  localparam int REPORT_LIMIT = 10;
  // Mode 3 has no name in the package; the core drops it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // Largest distance a new deadline may lie ahead of now.
  localparam logic [TW-1:0] MAX_DISTANCE = 32'h7FFF_FFFF;

  typedef struct {
    logic [TW-1:0]       deadline;
    logic [TAG_W-1:0]    tag;
    logic [ACTION_W-1:0] action;
  } timer_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
    logic [ACTION_W-1:0] action;
    logic                accepted;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [TPU_W-1:0]     cfg_wr_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [MODE_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]    m_tuser;
  logic                 m_tlast;

  // Predictor state: pending timers sorted by deadline, head first.
  timer_t         pending_timers[$];
  logic [TW-1:0]  now_ticks = '0;
  logic [TPU_W-1:0] tick_scale = 16'd1;
  result_t        awaited_results[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  quiet_flow = 1'b0;   // when set, neither side idles at random
  int  sink_hold_req = 0;   // long receiver hold-off asked by a test
  int  sink_wait = 0;
  result_t seen_result;
  result_t want_result;

  always #6 clk = ~clk;

  deadline_ordered_timer_queue_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // True when time a lies at or before time b, wrap-safe over the counter width.
  function automatic bit not_later(logic [TW-1:0] a, logic [TW-1:0] b);
    logic [TW-1:0] gap;
    gap = b - a;
    return !gap[TW-1];
  endfunction

  function automatic void await_result(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                                       logic [ACTION_W-1:0] action, logic accepted,
                                       logic [COUNT_W-1:0] count, logic last);
    result_t r;
    r = '{kind: kind, tag: tag, action: action, accepted: accepted, count: count,
          last: last};
    awaited_results.push_back(r);
  endfunction

  // Advance the predicted queue by one accepted item and queue its results.
  function automatic void predict_timer_item(logic [MODE_W-1:0] mode,
                                             logic [DELAY_W-1:0] delay,
                                             logic [TAG_W-1:0] tag,
                                             logic [ACTION_W-1:0] action);
    timer_t         t;
    timer_t         kept[$];
    logic [PROD_W-1:0] product;
    logic [TW-1:0]  distance;
    int             pos;
    int             hits;
    case (mode)
      MODE_REGISTER: begin
        if (pending_timers.size() >= QUEUE_DEPTH) begin
          // queue full: reject and leave the queue alone
          await_result(KIND_STATUS, '0, '0, 1'b0, '0, 1'b1);
        end else begin
          product = delay * tick_scale;
          distance = (product > MAX_DISTANCE) ? MAX_DISTANCE : product[TW-1:0];
          t.deadline = now_ticks + distance;
          t.tag = tag;
          t.action = action;
          // slot in behind every timer due at or before the new one
          pos = 0;
          while (pos < pending_timers.size() &&
                 not_later(pending_timers[pos].deadline, t.deadline)) begin
            pos++;
          end
          pending_timers.insert(pos, t);
          await_result(KIND_STATUS, '0, '0, 1'b1, '0, 1'b1);
        end
      end
      MODE_CANCEL: begin
        hits = 0;
        foreach (pending_timers[i]) begin
          if (pending_timers[i].tag == tag) begin
            hits++;
          end else begin
            kept.push_back(pending_timers[i]);
          end
        end
        pending_timers = kept;
        await_result(KIND_SUMMARY, '0, '0, 1'b0, COUNT_W'(hits), 1'b1);
      end
      MODE_TICK: begin
        hits = 0;
        now_ticks = now_ticks + 1'b1;
        while (pending_timers.size() != 0 &&
               not_later(pending_timers[0].deadline, now_ticks)) begin
          t = pending_timers.pop_front();
          await_result(KIND_FIRED, t.tag, t.action, 1'b0, '0, 1'b0);
          hits++;
        end
        await_result(KIND_SUMMARY, '0, '0, 1'b0, COUNT_W'(hits), 1'b1);
      end
      default: begin
        // unused mode: dropped, nothing comes back
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and hold it until the core takes it. Valid stays high after
  // the handshake so back-to-back items need no second assignment in one step.
  task automatic offer_timer_item(input logic [MODE_W-1:0] mode,
                                  input logic [DELAY_W-1:0] delay,
                                  input logic [TAG_W-1:0] tag,
                                  input logic [ACTION_W-1:0] action);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {action, tag, delay};
    do @(posedge clk); while (!s_tready);
    predict_timer_item(mode, delay, tag, action);
  endtask

  // Drop valid and wait until every awaited result has come back.
  task automatic settle_out();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // Write ticks_per_unit while the core is idle. A dropped mode-3 item gives
  // no result, so wait on past the last result, for such an item to leave the core.
  task automatic write_tick_scale(input logic [TPU_W-1:0] value);
    settle_out();
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tick_scale = value;
  endtask

  // Field extremes, every mode, FIFO order on equal deadlines, a cancel that
  // hits nothing and a dropped mode-3 item.
  task automatic test_basic_ops();
    offer_timer_item(MODE_REGISTER, 24'h000000, 16'h0000, 8'h00);
    offer_timer_item(MODE_REGISTER, 24'h000000, 16'hFFFF, 8'hFF);
    offer_timer_item(MODE_REGISTER, 24'h000002, 16'h1234, 8'h5A);
    offer_timer_item(MODE_REGISTER, 24'hFFFFFF, 16'hA5A5, 8'hC3);
    offer_timer_item(MODE_UNUSED,   24'hFFFFFF, 16'hFFFF, 8'hFF);
    offer_timer_item(MODE_TICK,     24'hFFFFFF, 16'hFFFF, 8'hFF);
    offer_timer_item(MODE_CANCEL,   24'h000000, 16'h5555, 8'h00);
    offer_timer_item(MODE_TICK,     24'h000000, 16'h0000, 8'h00);
    offer_timer_item(MODE_TICK,     24'h000000, 16'h0000, 8'h00);
    offer_timer_item(MODE_CANCEL,   24'h000000, 16'hA5A5, 8'h00);
    offer_timer_item(MODE_TICK,     24'h000000, 16'h0000, 8'h00);
  endtask

  // Scale extremes: zero puts every deadline at now, the top value saturates
  // the distance for large delays.
  task automatic test_scaling();
    write_tick_scale(16'd0);
    offer_timer_item(MODE_REGISTER, 24'hFFFFFF, 16'h0101, 8'h11);
    offer_timer_item(MODE_REGISTER, 24'h000001, 16'h0202, 8'h22);
    offer_timer_item(MODE_TICK,     24'h000000, 16'h0000, 8'h00);
    write_tick_scale(16'hFFFF);
    offer_timer_item(MODE_REGISTER, 24'hFFFFFF, 16'h0303, 8'h33);
    offer_timer_item(MODE_REGISTER, 24'h008000, 16'h0303, 8'h44);
    offer_timer_item(MODE_REGISTER, 24'h000001, 16'h0404, 8'h55);
    offer_timer_item(MODE_REGISTER, 24'h000000, 16'h0505, 8'h66);
    offer_timer_item(MODE_TICK,     24'h000000, 16'h0000, 8'h00);
    offer_timer_item(MODE_CANCEL,   24'h000000, 16'h0303, 8'h00);
    offer_timer_item(MODE_CANCEL,   24'h000000, 16'h0404, 8'h00);
    write_tick_scale(16'd1);
  endtask

  // Fill the queue, overflow it, then empty it in one tick (most results per
  // item) and once more in one cancel.
  task automatic test_capacity();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      offer_timer_item(MODE_REGISTER, 24'h000000, 16'(i * 16'h0801), 8'(~i));
    end
    offer_timer_item(MODE_REGISTER, 24'h000000, 16'hDEAD, 8'h99);
    offer_timer_item(MODE_TICK, 24'h000000, 16'h0000, 8'h00);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      offer_timer_item(MODE_REGISTER, 24'(16'hFFFF - i), 16'h7777, 8'(i));
    end
    offer_timer_item(MODE_REGISTER, 24'h000001, 16'h7777, 8'h01);
    offer_timer_item(MODE_TICK, 24'h000000, 16'h0000, 8'h00);
    offer_timer_item(MODE_CANCEL, 24'h000000, 16'h7777, 8'h00);
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // output register fills and the core stalls its input.
  task automatic test_backpressure();
    settle_out();
    quiet_flow = 1'b1;
    sink_hold_req = 400;
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0) begin
        offer_timer_item(MODE_REGISTER, 24'(i % 3), 16'(16'h0A00 + i), 8'(i));
      end else begin
        offer_timer_item(MODE_TICK, 24'h000000, 16'h0000, 8'h00);
      end
    end
    settle_out();
    quiet_flow = 1'b0;
  endtask

  // Mostly well-formed traffic: registers with short delays that ticks will
  // fire, cancels on a small tag pool, a few far deadlines and full-range
  // fields, and the odd dropped item that does not count.
  task automatic random_timer_items(input int n);
    logic [TAG_W-1:0]    tag_pool[6];
    logic [MODE_W-1:0]   mode;
    logic [DELAY_W-1:0]  delay;
    logic [TAG_W-1:0]    tag;
    logic [ACTION_W-1:0] action;
    int                  done;
    int                  r;
    tag_pool = '{16'h0001, 16'h00FF, 16'hBEEF, 16'h8000, 16'h0000, 16'hFFFF};
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) mode = MODE_REGISTER;
      else if (r < 80) mode = MODE_TICK;
      else if (r < 95) mode = MODE_CANCEL;
      else mode = MODE_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 70) delay = DELAY_W'($urandom_range(0, 6));
      else if (r < 85) delay = DELAY_W'($urandom_range(0, 200));
      else delay = DELAY_W'($urandom);
      tag = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom) : tag_pool[$urandom_range(0, 5)];
      action = ACTION_W'($urandom);
      offer_timer_item(mode, delay, tag, action);
      if (mode != MODE_UNUSED) done++;
    end
  endtask

  task automatic test_random();
    logic [TPU_W-1:0] scale;
    write_tick_scale(16'd1);
    random_timer_items(20);
    write_tick_scale(16'd0);
    random_timer_items(20);
    write_tick_scale(16'd3);
    quiet_flow = 1'b1;
    random_timer_items(20);
    quiet_flow = 1'b0;
    scale = TPU_W'($urandom_range(1, 65535));
    write_tick_scale(scale);
    random_timer_items(15);
  endtask

  // Receiver: short random stalls, the odd long one, and any long hold-off a
  // test asks for, counted down here cycle by cycle.
  always @(posedge clk) begin
    if (sink_hold_req != 0) begin
      sink_wait = sink_hold_req;
      sink_hold_req = 0;
    end
    if (sink_wait != 0) begin
      m_tready <= 1'b0;
      sink_wait--;
    end else begin
      m_tready <= 1'b1;
      if (!quiet_flow && $urandom_range(0, 99) < 20) begin
        sink_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
  end

  // Compare each result item taken from the core with the oldest awaited one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result = '{kind: m_tuser, tag: m_tdata[15:0], action: m_tdata[23:16],
                      accepted: m_tdata[24], count: m_tdata[30:25], last: m_tlast};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: unexpected result kind %0d tag %h action %h acc %0d count %0d last %0d",
                   $time, seen_result.kind, seen_result.tag, seen_result.action,
                   seen_result.accepted, seen_result.count, seen_result.last);
        end
      end else begin
        want_result = awaited_results.pop_front();
        if (seen_result !== want_result) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: expected kind %0d tag %h action %h acc %0d count %0d last %0d",
                     $time, want_result.kind, want_result.tag, want_result.action,
                     want_result.accepted, want_result.count, want_result.last);
            $display("%0t:      got kind %0d tag %h action %h acc %0d count %0d last %0d",
                     $time, seen_result.kind, seen_result.tag, seen_result.action,
                     seen_result.accepted, seen_result.count, seen_result.last);
          end
        end
      end
    end
  end

  // Hang guard: end the run if it goes far past any correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_scaling();
    test_capacity();
    test_backpressure();
    test_random();
    settle_out();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
